// File: rtl/osc_pkg.sv
// Package for the optical sensor two-wire configuration sequencer.
// Holds beat types, register file type, step codes and result codes; no dependencies.
package osc_pkg;

  localparam int WRITE_BITS = 15;
  localparam int READ_BITS  = 14;
  localparam int VOTE_NEED  = 2;

  localparam logic [2:0] FUNC_CONFIG = 3'd1;
  localparam logic [2:0] FUNC_WATCH  = 3'd2;
  localparam logic [2:0] FUNC_SLEEP  = 3'd3;
  localparam logic [2:0] FUNC_CHECK  = 3'd4;
  localparam logic [2:0] FUNC_LIGHT  = 3'd5;

  localparam logic [2:0] ST_S0    = 3'd0;
  localparam logic [2:0] ST_SLEEP = 3'd1;
  localparam logic [2:0] ST_WATCH = 3'd2;
  localparam logic [2:0] ST_S3    = 3'd3;
  localparam logic [2:0] ST_UNK   = 3'd4;

  localparam logic [2:0] RES_PASS   = 3'd0;
  localparam logic [2:0] RES_BUS    = 3'd1;
  localparam logic [2:0] RES_VERIFY = 3'd2;
  localparam logic [2:0] RES_WATCHF = 3'd3;
  localparam logic [2:0] RES_FALSE  = 3'd4;

  localparam logic [2:0] REG_CONFIG_WORD   = 3'd0;
  localparam logic [2:0] REG_DRIVE_DELAY   = 3'd1;
  localparam logic [2:0] REG_CHECK_DELAY   = 3'd2;
  localparam logic [2:0] REG_RECOVER_DELAY = 3'd3;
  localparam logic [2:0] REG_PULSE_LIMIT   = 3'd4;

  typedef enum logic [5:0] {
    P_IDLE, P_CHK,
    P_CF0, P_CF1, P_CF2, P_CF3, P_CF4, P_CF5, P_CFREL, P_CFS3,
    P_WDLO, P_WELO, P_WBIT, P_WEH, P_WEL, P_WT1, P_WT2, P_WT3, P_WREL,
    P_R0, P_R1, P_R2, P_R3, P_R4, P_R5, P_R6, P_REH, P_REL,
    P_RT1, P_RT2, P_RT3, P_RREL, P_CMP,
    P_GW0, P_GW1, P_A1, P_A2, P_A3, P_A4, P_A5, P_A6,
    P_B1, P_B2, P_B3, P_B4, P_B5, P_B6, P_B7, P_GW2,
    P_GS0, P_GS1, P_GS2, P_GS3, P_GS4,
    P_CB1, P_WL1, P_WLHI, P_WLLO
  } step_t;

  typedef struct packed {
    logic [2:0] func;
    logic       e_in;
    logic       d_in;
  } osc_in_t;

  typedef struct packed {
    logic        e_drive;
    logic        e_level;
    logic        d_drive;
    logic        d_level;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [2:0]  bus_state;
    logic        configured;
    logic [13:0] readback_value;
  } osc_out_t;

  typedef struct packed {
    logic [14:0] config_word;
    logic [7:0]  drive_delay;
    logic [7:0]  check_delay;
    logic [15:0] recovery_delay;
    logic [31:0] pulse_limit;
  } osc_cfg_t;

endpackage

// File: rtl/osc_seq.sv
// Pin sequencer: one delay count or step per accepted beat; forms the result beat.
// Depends on osc_pkg.
module osc_seq
  import osc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  osc_in_t  in_item,
  input  osc_cfg_t cfg,
  output osc_out_t res
);

  step_t       step_r, step_nxt, ret_r, ret_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] dcnt_r, dcnt_nxt;
  logic [3:0]  bitc_r, bitc_nxt;
  logic [15:0] shw_r, shw_nxt;
  logic [13:0] rdw_r, rdw_nxt;
  logic [1:0]  votes_r [4];
  logic [1:0]  votes_nxt [4];
  logic [1:0]  sidx_r, sidx_nxt;
  logic        cfgd_r, cfgd_nxt;
  logic [2:0]  last_r, last_nxt;
  logic [3:0]  pins_r, pins_nxt;
  logic [2:0]  rslt_r, rslt_nxt;
  logic        done;
  logic        wl;
  logic [1:0]  vidx;
  logic [31:0] drv_dly, chk_dly, rec_dly;

  assign drv_dly = {24'd0, (cfg.drive_delay == 8'd0) ? 8'd1 : cfg.drive_delay};
  assign chk_dly = {24'd0, (cfg.check_delay == 8'd0) ? 8'd1 : cfg.check_delay};
  assign rec_dly = {16'd0, (cfg.recovery_delay == 16'd0) ? 16'd1 : cfg.recovery_delay};
  assign wl      = (step_r == P_WLHI) || (step_r == P_WLLO);
  assign vidx    = {in_item.e_in, in_item.d_in};

  always_comb begin
    step_nxt = step_r;
    ret_nxt  = ret_r;
    cmd_nxt  = cmd_r;
    dcnt_nxt = dcnt_r;
    bitc_nxt = bitc_r;
    shw_nxt  = shw_r;
    rdw_nxt  = rdw_r;
    votes_nxt = votes_r;
    sidx_nxt = sidx_r;
    cfgd_nxt = cfgd_r;
    last_nxt = last_r;
    pins_nxt = pins_r;
    rslt_nxt = rslt_r;
    done     = 1'b0;
    if (step_r == P_IDLE) begin
      if (in_item.func >= FUNC_CONFIG && in_item.func <= FUNC_LIGHT) begin
        cmd_nxt  = in_item.func;
        dcnt_nxt = '0;
        case (in_item.func)
          FUNC_CONFIG: begin cfgd_nxt = 1'b0; step_nxt = P_CF0; end
          FUNC_WATCH:  step_nxt = P_GW0;
          FUNC_SLEEP:  step_nxt = P_GS0;
          FUNC_CHECK:  begin step_nxt = P_CHK; ret_nxt = P_CB1; end
          default:     begin step_nxt = P_CHK; ret_nxt = P_WL1; end
        endcase
      end
    end else if (!wl && dcnt_r > 32'd1) begin
      dcnt_nxt = dcnt_r - 32'd1;
    end else begin
      if (!wl) dcnt_nxt = '0;
      unique case (step_r)
        P_CHK: begin
          votes_nxt[vidx] = votes_r[vidx] + 2'd1;
          sidx_nxt = sidx_r + 2'd1;
          dcnt_nxt = chk_dly;
          if (sidx_nxt >= 2'd3) begin
            if (votes_nxt[1] >= 2'(VOTE_NEED))      last_nxt = ST_SLEEP;
            else if (votes_nxt[2] >= 2'(VOTE_NEED)) last_nxt = ST_WATCH;
            else if (votes_nxt[3] >= 2'(VOTE_NEED)) last_nxt = ST_S3;
            else if (votes_nxt[0] >= 2'(VOTE_NEED)) last_nxt = ST_S0;
            else                                    last_nxt = ST_UNK;
            for (int i = 0; i < 4; i++) votes_nxt[i] = '0;
            sidx_nxt = '0;
            step_nxt = ret_r;
          end
        end
        P_CF0: begin pins_nxt = 4'b1000; dcnt_nxt = drv_dly; step_nxt = P_CF1; end
        P_CF1: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_CF2; end
        P_CF2: begin pins_nxt[3:2] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_CF3; end
        P_CF3: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_CF4; end
        P_CF4: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_CF5; end
        P_CF5: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_CFREL; end
        P_CFREL: begin
          pins_nxt = pins_r & 4'b0101; dcnt_nxt = 32'd1;
          step_nxt = P_CHK; ret_nxt = P_CFS3;
        end
        P_CFS3: begin
          if (last_r != ST_S3) begin
            rslt_nxt = RES_BUS; done = 1'b1;
          end else begin
            shw_nxt = 16'({1'b0, cfg.config_word} << (16 - WRITE_BITS));
            pins_nxt = 4'b1111; dcnt_nxt = drv_dly; step_nxt = P_WDLO;
          end
        end
        P_WDLO: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_WELO; end
        P_WELO: begin
          pins_nxt[3:2] = 2'b10; bitc_nxt = '0; dcnt_nxt = drv_dly; step_nxt = P_WBIT;
        end
        P_WBIT: begin
          pins_nxt[1:0] = {1'b1, shw_r[15]};
          shw_nxt = {shw_r[14:0], 1'b0};
          dcnt_nxt = drv_dly; step_nxt = P_WEH;
        end
        P_WEH: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_WEL; end
        P_WEL: begin
          pins_nxt[3:2] = 2'b10; dcnt_nxt = drv_dly;
          if ({1'b0, bitc_r} + 5'd1 >= 5'(WRITE_BITS)) step_nxt = P_WT1;
          else begin bitc_nxt = bitc_r + 4'd1; step_nxt = P_WBIT; end
        end
        P_WT1: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_WT2; end
        P_WT2: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_WT3; end
        P_WT3: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_WREL; end
        P_WREL: begin pins_nxt = pins_r & 4'b0101; dcnt_nxt = 32'd1; step_nxt = P_R0; end
        P_R0: begin pins_nxt = 4'b1111; rdw_nxt = '0; dcnt_nxt = drv_dly; step_nxt = P_R1; end
        P_R1: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_R2; end
        P_R2: begin pins_nxt[3:2] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_R3; end
        P_R3: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_R4; end
        P_R4: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_R5; end
        P_R5: begin pins_nxt[1:0] = 2'b01; dcnt_nxt = drv_dly; step_nxt = P_R6; end
        P_R6: begin
          pins_nxt[3:2] = 2'b10; bitc_nxt = '0; dcnt_nxt = drv_dly; step_nxt = P_REH;
        end
        P_REH: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_REL; end
        P_REL: begin
          rdw_nxt = {rdw_r[12:0], in_item.d_in};
          pins_nxt[3:2] = 2'b10; dcnt_nxt = drv_dly;
          if ({1'b0, bitc_r} + 5'd1 >= 5'(READ_BITS)) step_nxt = P_RT1;
          else begin bitc_nxt = bitc_r + 4'd1; step_nxt = P_REH; end
        end
        P_RT1: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_RT2; end
        P_RT2: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_RT3; end
        P_RT3: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = drv_dly; step_nxt = P_RREL; end
        P_RREL: begin pins_nxt = pins_r & 4'b0101; dcnt_nxt = 32'd1; step_nxt = P_CMP; end
        P_CMP: begin
          if ({1'b0, rdw_r} != cfg.config_word) begin
            rslt_nxt = RES_VERIFY; done = 1'b1;
          end else begin
            cfgd_nxt = 1'b1; step_nxt = P_GW0;
          end
        end
        P_GW0: begin
          if (!cfgd_r) begin
            rslt_nxt = (cmd_r == FUNC_CONFIG) ? RES_WATCHF : RES_FALSE; done = 1'b1;
          end else begin
            step_nxt = P_CHK; ret_nxt = P_GW1;
          end
        end
        P_GW1: begin
          if (last_r == ST_SLEEP) step_nxt = P_A1;
          else if (last_r == ST_WATCH) begin rslt_nxt = RES_PASS; done = 1'b1; end
          else if (last_r == ST_S3) step_nxt = P_B1;
          else begin
            rslt_nxt = (cmd_r == FUNC_CONFIG) ? RES_WATCHF : RES_FALSE; done = 1'b1;
          end
        end
        P_A1: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = 32'd1; step_nxt = P_A2; end
        P_A2: begin pins_nxt[3:2] = 2'b10; dcnt_nxt = 32'd1; step_nxt = P_A3; end
        P_A3: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = 32'd1; step_nxt = P_A4; end
        P_A4: begin pins_nxt[1:0] = 2'b00; dcnt_nxt = 32'd1; step_nxt = P_A5; end
        P_A5: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = 32'd1; step_nxt = P_A6; end
        P_A6: begin
          pins_nxt[3:2] = 2'b01; dcnt_nxt = rec_dly; step_nxt = P_CHK; ret_nxt = P_GW2;
        end
        P_B1: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = 32'd1; step_nxt = P_B2; end
        P_B2: begin pins_nxt[1:0] = 2'b11; dcnt_nxt = 32'd1; step_nxt = P_B3; end
        P_B3: begin pins_nxt[3:2] = 2'b10; dcnt_nxt = 32'd1; step_nxt = P_B4; end
        P_B4: begin pins_nxt[1:0] = 2'b10; dcnt_nxt = 32'd1; step_nxt = P_B5; end
        P_B5: begin pins_nxt[1:0] = 2'b00; dcnt_nxt = 32'd1; step_nxt = P_B6; end
        P_B6: begin pins_nxt[3:2] = 2'b11; dcnt_nxt = 32'd1; step_nxt = P_B7; end
        P_B7: begin
          pins_nxt[3:2] = 2'b01; dcnt_nxt = rec_dly; step_nxt = P_CHK; ret_nxt = P_GW2;
        end
        P_GW2: begin
          done = 1'b1;
          if (last_r == ST_WATCH) rslt_nxt = RES_PASS;
          else rslt_nxt = (cmd_r == FUNC_CONFIG) ? RES_WATCHF : RES_FALSE;
        end
        P_GS0: begin
          if (!cfgd_r) begin rslt_nxt = RES_FALSE; done = 1'b1; end
          else begin step_nxt = P_CHK; ret_nxt = P_GS1; end
        end
        P_GS1: begin
          if (last_r == ST_SLEEP) begin rslt_nxt = RES_PASS; done = 1'b1; end
          else if (last_r == ST_WATCH) step_nxt = P_GS2;
          else begin rslt_nxt = RES_FALSE; done = 1'b1; end
        end
        P_GS2: begin pins_nxt[3:2] = 2'b10; dcnt_nxt = drv_dly; step_nxt = P_GS3; end
        P_GS3: begin
          pins_nxt[3:2] = 2'b00; dcnt_nxt = drv_dly; step_nxt = P_CHK; ret_nxt = P_GS4;
        end
        P_GS4: begin
          rslt_nxt = (last_r == ST_SLEEP) ? RES_PASS : RES_FALSE; done = 1'b1;
        end
        P_CB1: begin rslt_nxt = RES_PASS; done = 1'b1; end
        P_WL1: begin
          if (last_r != ST_S0) begin rslt_nxt = RES_PASS; done = 1'b1; end
          else begin dcnt_nxt = cfg.pulse_limit; step_nxt = P_WLHI; end
        end
        P_WLHI, P_WLLO: begin
          if (step_r == P_WLHI && in_item.d_in) begin
            step_nxt = P_WLLO;
            if (dcnt_r != 32'd0) dcnt_nxt = dcnt_r - 32'd1;
          end else if (step_r == P_WLLO && !in_item.d_in) begin
            rslt_nxt = RES_PASS; done = 1'b1;
          end else if (dcnt_r == 32'd0) begin
            rslt_nxt = RES_FALSE; done = 1'b1;
          end else begin
            dcnt_nxt = dcnt_r - 32'd1;
          end
        end
        default: begin step_nxt = P_IDLE; cmd_nxt = '0; end
      endcase
      // completion: drop back to idle
      if (done) begin
        step_nxt = P_IDLE; cmd_nxt = '0; dcnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= P_IDLE;
      ret_r  <= P_IDLE;
      cmd_r  <= '0;
      dcnt_r <= '0;
      bitc_r <= '0;
      shw_r  <= '0;
      rdw_r  <= '0;
      for (int i = 0; i < 4; i++) votes_r[i] <= '0;
      sidx_r <= '0;
      cfgd_r <= 1'b0;
      last_r <= ST_UNK;
      pins_r <= '0;
      rslt_r <= RES_PASS;
    end else if (step_en) begin
      step_r <= step_nxt;
      ret_r  <= ret_nxt;
      cmd_r  <= cmd_nxt;
      dcnt_r <= dcnt_nxt;
      bitc_r <= bitc_nxt;
      shw_r  <= shw_nxt;
      rdw_r  <= rdw_nxt;
      votes_r <= votes_nxt;
      sidx_r <= sidx_nxt;
      cfgd_r <= cfgd_nxt;
      last_r <= last_nxt;
      pins_r <= pins_nxt;
      rslt_r <= rslt_nxt;
    end
  end

  always_comb begin
    res.e_drive        = pins_nxt[3];
    res.e_level        = pins_nxt[2];
    res.d_drive        = pins_nxt[1];
    res.d_level        = pins_nxt[0];
    res.busy_res       = (step_nxt != P_IDLE);
    res.done_res       = done;
    res.status         = rslt_nxt;
    res.bus_state      = last_nxt;
    res.configured     = cfgd_nxt;
    res.readback_value = rdw_nxt;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> step_nxt == P_IDLE) else $error("done without return to idle");
  a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r != 2'd3) else $error("sample index out of range");
  a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == P_IDLE |-> cmd_r == 3'd0) else $error("command held while idle");
`endif

endmodule

// File: rtl/optical_sensor_config_bus_controller_top.sv
// Top level of the optical sensor two-wire configuration controller.
// Depends on osc_pkg and osc_seq.
//
//  channel | ports                        | beat
//  --------+------------------------------+-----------------------------------
//  in      | in_valid/in_ready/in_data    | one tick: func, e_in, d_in
//  out     | out_valid/out_ready/out_data | pin latch, busy, done, status, ...
//  cfg     | cfg_psel..cfg_prdata (APB)   | 32-bit register write/read
//
// One beat enters per cycle while out is not stalled; each beat moves the sequencer
// on by one delay count or step; its result is held in the output register.
// The output register decouples the sides: a new beat is taken while the
// previous result is taken in the same cycle. Stalls on out hold in_ready low.
// Reset (rst_n, synchronous) returns to idle, pins released, bus state unknown.
module optical_sensor_config_bus_controller_top
  import osc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  osc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output osc_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  osc_cfg_t   cfg_r;
  osc_out_t   res;
  osc_out_t   out_data_r;
  logic       out_valid_r;
  logic       accept;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register file: write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.config_word    <= '0;
      cfg_r.drive_delay    <= 8'd1;
      cfg_r.check_delay    <= 8'd1;
      cfg_r.recovery_delay <= 16'd100;
      cfg_r.pulse_limit    <= 32'd500000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CONFIG_WORD:   cfg_r.config_word    <= cfg_pwdata[14:0];
        REG_DRIVE_DELAY:   cfg_r.drive_delay    <= cfg_pwdata[7:0];
        REG_CHECK_DELAY:   cfg_r.check_delay    <= cfg_pwdata[7:0];
        REG_RECOVER_DELAY: cfg_r.recovery_delay <= cfg_pwdata[15:0];
        REG_PULSE_LIMIT:   cfg_r.pulse_limit    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CONFIG_WORD:   cfg_prdata = {17'd0, cfg_r.config_word};
      REG_DRIVE_DELAY:   cfg_prdata = {24'd0, cfg_r.drive_delay};
      REG_CHECK_DELAY:   cfg_prdata = {24'd0, cfg_r.check_delay};
      REG_RECOVER_DELAY: cfg_prdata = {16'd0, cfg_r.recovery_delay};
      REG_PULSE_LIMIT:   cfg_prdata = cfg_r.pulse_limit;
      default:           cfg_prdata = '0;
    endcase
  end

  // take a beat whenever the result slot is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  osc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .in_item (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready) else $error("input stalled with empty result slot");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done beat still busy");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r) else $error("accepted beat lost");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for optical_sensor_config_bus_controller_top.
// Depends on osc_pkg; predicts every result beat and checks it field by field.
module tb;
  import osc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  osc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  osc_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  optical_sensor_config_bus_controller_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model: own copy of registers and state, one tick per beat.
  // ---------------------------------------------------------------------------
  logic [14:0] word_reg;
  logic [7:0]  drive_reg, check_reg;
  logic [15:0] recover_reg;
  logic [31:0] timeout_reg;

  step_t       seq_step, check_ret;
  logic [2:0]  cmd_now, voted_state, last_result;
  logic [31:0] dly;
  logic [3:0]  bit_idx;
  logic [15:0] tx_word, rx_word;
  logic [1:0]  votes [4];
  logic [1:0]  n_samples;
  logic        is_configured, cmd_done;
  logic [3:0]  pin_latch;  // e_drive, e_level, d_drive, d_level

  function automatic logic [31:0] at_least_one(logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  task automatic model_reset();
    word_reg = '0; drive_reg = 8'd1; check_reg = 8'd1;
    recover_reg = 16'd100; timeout_reg = 32'd500000;
    seq_step = P_IDLE; check_ret = P_IDLE; cmd_now = '0; dly = '0;
    bit_idx = '0; tx_word = '0; rx_word = '0; n_samples = '0;
    for (int i = 0; i < 4; i++) votes[i] = '0;
    is_configured = 1'b0; voted_state = ST_UNK; pin_latch = '0; last_result = RES_PASS;
  endtask

  task automatic drive_wait(step_t nxt);
    dly = at_least_one({24'd0, drive_reg});
    seq_step = nxt;
  endtask

  task automatic single_wait(step_t nxt);
    dly = 32'd1;
    seq_step = nxt;
  endtask

  task automatic start_check(step_t ret);
    seq_step = P_CHK;
    check_ret = ret;
  endtask

  task automatic complete(logic [2:0] code);
    last_result = code; seq_step = P_IDLE; cmd_now = '0; dly = '0; cmd_done = 1'b1;
  endtask

  task automatic watch_complete(logic ok);
    if (cmd_now == FUNC_CONFIG) complete(ok ? RES_PASS : RES_WATCHF);
    else complete(ok ? RES_PASS : RES_FALSE);
  endtask

  task automatic advance_step(logic e, logic d);
    int idx;
    logic high_wait;
    case (seq_step)
      P_CHK: begin
        idx = d ? (e ? 3 : 1) : (e ? 2 : 0);
        votes[idx] = votes[idx] + 2'd1;
        n_samples = n_samples + 2'd1;
        dly = at_least_one({24'd0, check_reg});
        if (n_samples >= 3) begin
          if (votes[1] >= VOTE_NEED) voted_state = ST_SLEEP;
          else if (votes[2] >= VOTE_NEED) voted_state = ST_WATCH;
          else if (votes[3] >= VOTE_NEED) voted_state = ST_S3;
          else if (votes[0] >= VOTE_NEED) voted_state = ST_S0;
          else voted_state = ST_UNK;
          for (int i = 0; i < 4; i++) votes[i] = '0;
          n_samples = '0;
          seq_step = check_ret;
        end
      end
      P_CF0: begin pin_latch = 4'b1000; drive_wait(P_CF1); end
      P_CF1: begin pin_latch[3:2] = 2'b11; drive_wait(P_CF2); end
      P_CF2: begin pin_latch[3:2] = 2'b10; drive_wait(P_CF3); end
      P_CF3: begin pin_latch[3:2] = 2'b11; drive_wait(P_CF4); end
      P_CF4: begin pin_latch[1:0] = 2'b10; drive_wait(P_CF5); end
      P_CF5: begin pin_latch[1:0] = 2'b11; drive_wait(P_CFREL); end
      P_CFREL: begin pin_latch &= 4'b0101; dly = 32'd1; start_check(P_CFS3); end
      P_CFS3: begin
        if (voted_state != ST_S3) complete(RES_BUS);
        else begin
          tx_word = {word_reg, 1'b0};
          pin_latch = 4'hF;
          drive_wait(P_WDLO);
        end
      end
      P_WDLO: begin pin_latch[1:0] = 2'b10; drive_wait(P_WELO); end
      P_WELO: begin pin_latch[3:2] = 2'b10; bit_idx = '0; drive_wait(P_WBIT); end
      P_WBIT: begin
        pin_latch[1:0] = {1'b1, tx_word[15]};
        tx_word = tx_word << 1;
        drive_wait(P_WEH);
      end
      P_WEH: begin pin_latch[3:2] = 2'b11; drive_wait(P_WEL); end
      P_WEL: begin
        pin_latch[3:2] = 2'b10;
        if (bit_idx + 1 >= WRITE_BITS) drive_wait(P_WT1);
        else begin bit_idx = bit_idx + 4'd1; drive_wait(P_WBIT); end
      end
      P_WT1: begin pin_latch[1:0] = 2'b10; drive_wait(P_WT2); end
      P_WT2: begin pin_latch[3:2] = 2'b11; drive_wait(P_WT3); end
      P_WT3: begin pin_latch[1:0] = 2'b11; drive_wait(P_WREL); end
      P_WREL: begin pin_latch &= 4'b0101; single_wait(P_R0); end
      P_R0: begin pin_latch = 4'hF; rx_word = '0; drive_wait(P_R1); end
      P_R1: begin pin_latch[1:0] = 2'b10; drive_wait(P_R2); end
      P_R2: begin pin_latch[3:2] = 2'b10; drive_wait(P_R3); end
      P_R3: begin pin_latch[1:0] = 2'b11; drive_wait(P_R4); end
      P_R4: begin pin_latch[3:2] = 2'b11; drive_wait(P_R5); end
      P_R5: begin pin_latch[1:0] = 2'b01; drive_wait(P_R6); end
      P_R6: begin pin_latch[3:2] = 2'b10; bit_idx = '0; drive_wait(P_REH); end
      P_REH: begin pin_latch[3:2] = 2'b11; drive_wait(P_REL); end
      P_REL: begin
        rx_word = {rx_word[14:0], d};
        pin_latch[3:2] = 2'b10;
        if (bit_idx + 1 >= READ_BITS) drive_wait(P_RT1);
        else begin bit_idx = bit_idx + 4'd1; drive_wait(P_REH); end
      end
      P_RT1: begin pin_latch[1:0] = 2'b10; drive_wait(P_RT2); end
      P_RT2: begin pin_latch[3:2] = 2'b11; drive_wait(P_RT3); end
      P_RT3: begin pin_latch[1:0] = 2'b11; drive_wait(P_RREL); end
      P_RREL: begin pin_latch &= 4'b0101; single_wait(P_CMP); end
      P_CMP: begin
        if (rx_word != {1'b0, word_reg}) complete(RES_VERIFY);
        else begin is_configured = 1'b1; seq_step = P_GW0; end
      end
      P_GW0: begin
        if (!is_configured) watch_complete(1'b0);
        else start_check(P_GW1);
      end
      P_GW1: begin
        if (voted_state == ST_SLEEP) seq_step = P_A1;
        else if (voted_state == ST_WATCH) watch_complete(1'b1);
        else if (voted_state == ST_S3) seq_step = P_B1;
        else watch_complete(1'b0);
      end
      P_A1: begin pin_latch[1:0] = 2'b11; single_wait(P_A2); end
      P_A2: begin pin_latch[3:2] = 2'b10; single_wait(P_A3); end
      P_A3: begin pin_latch[1:0] = 2'b10; single_wait(P_A4); end
      P_A4: begin pin_latch[1:0] = 2'b00; single_wait(P_A5); end
      P_A5: begin pin_latch[3:2] = 2'b11; single_wait(P_A6); end
      P_A6, P_B7: begin
        pin_latch[3:2] = 2'b01;
        dly = at_least_one({16'd0, recover_reg});
        start_check(P_GW2);
      end
      P_B1: begin pin_latch[3:2] = 2'b11; single_wait(P_B2); end
      P_B2: begin pin_latch[1:0] = 2'b11; single_wait(P_B3); end
      P_B3: begin pin_latch[3:2] = 2'b10; single_wait(P_B4); end
      P_B4: begin pin_latch[1:0] = 2'b10; single_wait(P_B5); end
      P_B5: begin pin_latch[1:0] = 2'b00; single_wait(P_B6); end
      P_B6: begin pin_latch[3:2] = 2'b11; single_wait(P_B7); end
      P_GW2: watch_complete(voted_state == ST_WATCH);
      P_GS0: begin
        if (!is_configured) complete(RES_FALSE);
        else start_check(P_GS1);
      end
      P_GS1: begin
        if (voted_state == ST_SLEEP) complete(RES_PASS);
        else if (voted_state == ST_WATCH) seq_step = P_GS2;
        else complete(RES_FALSE);
      end
      P_GS2: begin pin_latch[3:2] = 2'b10; drive_wait(P_GS3); end
      P_GS3: begin
        pin_latch[3:2] = 2'b00;
        dly = at_least_one({24'd0, drive_reg});
        start_check(P_GS4);
      end
      P_GS4: complete(voted_state == ST_SLEEP ? RES_PASS : RES_FALSE);
      P_CB1: complete(RES_PASS);
      P_WL1: begin
        if (voted_state != ST_S0) complete(RES_PASS);
        else begin dly = timeout_reg; seq_step = P_WLHI; end
      end
      P_WLHI, P_WLLO: begin
        high_wait = (seq_step == P_WLHI);
        if (high_wait && d) seq_step = P_WLLO;
        if (!high_wait && !d) complete(RES_PASS);
        else if (!(high_wait && d) && dly == 0) complete(RES_FALSE);
        else if (dly != 0) dly = dly - 1;
      end
      default: begin seq_step = P_IDLE; cmd_now = '0; end
    endcase
  endtask

  task automatic sensor_tick(input osc_in_t t, output osc_out_t r);
    cmd_done = 1'b0;
    if (seq_step == P_IDLE) begin
      if (t.func >= FUNC_CONFIG && t.func <= FUNC_LIGHT) begin
        cmd_now = t.func;
        dly = '0;
        case (t.func)
          FUNC_CONFIG: begin is_configured = 1'b0; seq_step = P_CF0; end
          FUNC_WATCH:  seq_step = P_GW0;
          FUNC_SLEEP:  seq_step = P_GS0;
          FUNC_CHECK:  start_check(P_CB1);
          default:     start_check(P_WL1);
        endcase
      end
    end else if (seq_step != P_WLHI && seq_step != P_WLLO && dly > 1) begin
      dly = dly - 1;
    end else begin
      if (seq_step != P_WLHI && seq_step != P_WLLO) dly = '0;
      advance_step(t.e_in, t.d_in);
    end
    r = '0;
    {r.e_drive, r.e_level, r.d_drive, r.d_level} = pin_latch;
    r.busy_res = (seq_step != P_IDLE);
    r.done_res = cmd_done;
    r.status = last_result;
    r.bus_state = voted_state;
    r.configured = is_configured;
    r.readback_value = rx_word[13:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tick generation: pin levels follow what a cooperative sensor would show,
  // with some noise. Targets: S0, sleep, watch, S3, and SPREAD for an unknown vote.
  // ---------------------------------------------------------------------------
  localparam int SPREAD = 4;
  localparam int ANY    = 5;

  osc_in_t  sensor_ticks_q [$];
  osc_out_t expected_beats_q [$];
  int       forced_target = ANY;
  int       chk_target = 0;
  int       commands_sent = 0;
  int       ticks_queued = 0;

  task automatic pins_for_state(int s, output logic e, output logic d);
    case (s)
      0: {e, d} = 2'b00;
      1: {e, d} = 2'b01;
      2: {e, d} = 2'b10;
      default: {e, d} = 2'b11;
    endcase
  endtask

  task automatic queue_tick(logic [2:0] func);
    osc_in_t  t;
    osc_out_t r;
    t.func = func;
    t.e_in = 1'($urandom_range(0, 1));
    t.d_in = 1'($urandom_range(0, 1));
    if (seq_step == P_CHK) begin
      if (n_samples == 0) begin
        if (forced_target != ANY) chk_target = forced_target;
        else if ($urandom_range(0, 9) < 2) chk_target = $urandom_range(0, 4);
        else if (check_ret == P_CFS3) chk_target = 3;
        else if (check_ret == P_GW2) chk_target = 2;
        else if (check_ret == P_GS4) chk_target = 1;
        else chk_target = $urandom_range(1, 3);
      end
      if (chk_target == SPREAD) pins_for_state(n_samples, t.e_in, t.d_in);
      else if (forced_target != ANY || $urandom_range(0, 19) != 0)
        pins_for_state(chk_target, t.e_in, t.d_in);
    end else if (seq_step == P_REL) begin
      // answer with the expected readback bit, MSB first, rarely wrong
      if ($urandom_range(0, 99) != 0) t.d_in = word_reg[13 - bit_idx];
    end else if (seq_step == P_WLHI || seq_step == P_WLLO) begin
      t.d_in = (forced_target == ANY) ? ($urandom_range(0, 7) == 0) : (seq_step == P_WLHI);
    end
    if (seq_step == P_IDLE && func != 3'd0) commands_sent++;
    sensor_tick(t, r);
    sensor_ticks_q.push_back(t);
    expected_beats_q.push_back(r);
    ticks_queued++;
  endtask

  task automatic finish_sequence();
    while (seq_step != P_IDLE)
      queue_tick($urandom_range(0, 9) == 0 ? 3'($urandom_range(1, 7)) : 3'd0);
  endtask

  task automatic directed_cmd(logic [2:0] func, int target);
    forced_target = target;
    queue_tick(func);
    finish_sequence();
    forced_target = ANY;
  endtask

  // random commands until about n_ticks beats are queued, then let the last one end
  task automatic random_phase(int n_ticks);
    int start;
    start = ticks_queued;
    while (ticks_queued - start < n_ticks) begin
      if (seq_step == P_IDLE && $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 3) == 0) queue_tick(FUNC_CONFIG);
        else queue_tick(3'($urandom_range(0, 7)));
      end else begin
        queue_tick($urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'd0);
      end
    end
    finish_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: hold each beat until accepted, random gaps between beats.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int beats_in = 0;
  int beats_out = 0;

  function automatic int pick_gap(int n);
    if (n % 200 < 40) return 0;  // burst with no idling
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return $urandom_range(1, 3);
      default:       return $urandom_range(10, 40);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) beats_in <= beats_in + 1;
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sensor_ticks_q.size() != 0) begin
          in_data  <= sensor_ticks_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap(beats_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off once enough beats went by
  // so the output register fills and backs up the input side.
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!long_hold_done && beats_out >= 300) begin
      long_hold_done <= 1'b1;
      stall_left <= 400;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap(beats_out + 100);
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every result beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  int mismatches = 0;

  always @(posedge clk) begin
    osc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (expected_beats_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %h", out_data);
      end else begin
        want = expected_beats_q.pop_front();
        if (out_data.e_drive !== want.e_drive || out_data.e_level !== want.e_level ||
            out_data.d_drive !== want.d_drive || out_data.d_level !== want.d_level ||
            out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res ||
            out_data.status !== want.status || out_data.bus_state !== want.bus_state ||
            out_data.configured !== want.configured ||
            out_data.readback_value !== want.readback_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("beat %0d: pins exp %b got %b busy/done exp %b%b got %b%b",
                     beats_out, {want.e_drive, want.e_level, want.d_drive, want.d_level},
                     {out_data.e_drive, out_data.e_level, out_data.d_drive,
                      out_data.d_level},
                     want.busy_res, want.done_res, out_data.busy_res, out_data.done_res);
            $display("  status exp %0d got %0d bus exp %0d got %0d cfg exp %b got %b",
                     want.status, out_data.status, want.bus_state, out_data.bus_state,
                     want.configured, out_data.configured);
            $display("  rb exp %h got %h", want.readback_value, out_data.readback_value);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes: setup cycle then access cycle, only while idle.
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_CONFIG_WORD:   word_reg = value[14:0];
      REG_DRIVE_DELAY:   drive_reg = value[7:0];
      REG_CHECK_DELAY:   check_reg = value[7:0];
      REG_RECOVER_DELAY: recover_reg = value[15:0];
      default:           timeout_reg = value;
    endcase
  endtask

  task automatic drain();
    while (sensor_ticks_q.size() != 0 || expected_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] w, logic [31:0] dd, logic [31:0] cd,
                               logic [31:0] rd, logic [31:0] lt);
    drain();
    reg_write(REG_CONFIG_WORD, w);
    reg_write(REG_DRIVE_DELAY, dd);
    reg_write(REG_CHECK_DELAY, cd);
    reg_write(REG_RECOVER_DELAY, rd);
    reg_write(REG_PULSE_LIMIT, lt);
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: ignored codes, unconfigured watch and
    // sleep, each vote outcome and both light wait paths.
    directed_cmd(3'd6, ANY);
    directed_cmd(3'd7, ANY);
    directed_cmd(FUNC_WATCH, ANY);
    directed_cmd(FUNC_SLEEP, ANY);
    for (int s = 0; s <= SPREAD; s++) directed_cmd(FUNC_CHECK, s);
    directed_cmd(FUNC_LIGHT, 3);
    directed_cmd(FUNC_LIGHT, 0);

    // Configure with commands thrown at it while busy, then watch/sleep once
    // configured; short recovery keeps the run compact.
    load_settings(32'h1234, 1, 1, 3, 20);
    directed_cmd(FUNC_CONFIG, ANY);
    directed_cmd(FUNC_SLEEP, 2);
    directed_cmd(FUNC_WATCH, 1);
    directed_cmd(FUNC_WATCH, 3);
    directed_cmd(FUNC_CONFIG, 0);

    random_phase(70);
    load_settings(32'h3FFF, 0, 0, 0, 0);
    random_phase(70);
    load_settings(32'h0000, 2, 3, 5, 7);
    random_phase(70);
    load_settings(32'h7FFF, 1, 2, 1, 1);
    random_phase(60);
    load_settings(32'h2AAA, 1, 1, 2, 3);
    random_phase(70);
    // Largest pulse limit: one light wait that ends on the pulse.
    load_settings(32'h2AAA, 1, 1, 2, 32'hFFFF_FFFF);
    directed_cmd(FUNC_LIGHT, 0);
    drain();

    $display("Ran %0d commands over %0d result beats under several register settings,",
             commands_sent, beats_out);
    $display("including zero delays, the largest pulse limit and a long output hold-off.");
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
